// ===== hw/rtl/spwm_pkg.sv =====
// Package for the sine PWM modulator: types, constants and the sine table.
package spwm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int AMP_STEPS   = 10;
  localparam int ROM_SIZE    = 64;
  localparam int ROM_AW      = $clog2(ROM_SIZE);
  localparam int PHASE_W     = $clog2(TABLE_DEPTH);
  localparam int LVL_W       = 4;
  localparam int CMP_W       = 16;
  localparam int PERIOD_W    = 16;

  localparam int JOB_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2499;

  // 0.5 of full scale in the (level * sample) domain, and 2^23/10 rounded up
  localparam logic signed [21:0] HALF_SCALE = 22'sd327680;
  localparam logic [19:0]        RECIP_TEN  = 20'd838861;

  typedef enum logic [0:0] {
    OP_TICK = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    logic [ROM_AW-1:0] addr;
    logic [LVL_W-1:0]  level;
  } job_t;

  typedef struct packed {
    logic [CMP_W-1:0] compare;
    logic [LVL_W-1:0] level;
  } res_t;

  localparam logic signed [15:0] SINE_ROM [ROM_SIZE] = '{
         16'sd0,   16'sd3212,   16'sd6393,   16'sd9512,
     16'sd12540,  16'sd15447,  16'sd18205,  16'sd20788,
     16'sd23170,  16'sd25330,  16'sd27246,  16'sd28899,
     16'sd30274,  16'sd31357,  16'sd32138,  16'sd32610,
     16'sd32767,  16'sd32610,  16'sd32138,  16'sd31357,
     16'sd30274,  16'sd28899,  16'sd27246,  16'sd25330,
     16'sd23170,  16'sd20788,  16'sd18205,  16'sd15447,
     16'sd12540,   16'sd9512,   16'sd6393,   16'sd3212,
         16'sd0,  -16'sd3212,  -16'sd6393,  -16'sd9512,
    -16'sd12540, -16'sd15447, -16'sd18205, -16'sd20788,
    -16'sd23170, -16'sd25330, -16'sd27246, -16'sd28899,
    -16'sd30274, -16'sd31357, -16'sd32138, -16'sd32610,
    -16'sd32767, -16'sd32610, -16'sd32138, -16'sd31357,
    -16'sd30274, -16'sd28899, -16'sd27246, -16'sd25330,
    -16'sd23170, -16'sd20788, -16'sd18205, -16'sd15447,
    -16'sd12540,  -16'sd9512,  -16'sd6393,  -16'sd3212
  };

  // Map a phase step onto the sine table when the two depths differ
  function automatic logic [ROM_AW-1:0] rom_addr(input logic [PHASE_W-1:0] phase);
    int unsigned scaled;
    scaled = (32'(phase) * ROM_SIZE) / TABLE_DEPTH;
    return scaled[ROM_AW-1:0];
  endfunction

endpackage

// ===== hw/rtl/spwm_fifo.sv =====
// Small register queue with push/full and pop/empty sides; DEPTH is a power of two.
module spwm_fifo
  import spwm_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wptr;
  logic [AW:0]      rptr;

  assign empty = (wptr == rptr);
  assign full  = (wptr[AW] != rptr[AW]) && (wptr[AW-1:0] == rptr[AW-1:0]);
  assign rdata = mem[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr[AW-1:0]] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/spwm_front.sv =====
// Front end: accepts items, tracks phase and amplitude level, queues PWM jobs.
module spwm_front
  import spwm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [0:0] opcode,
  input  logic [0:0] clockwise,
  input  logic       full,
  output logic       job_push,
  output job_t       job
);

  logic [PHASE_W-1:0] phase;
  logic [LVL_W-1:0]   level;
  logic               accept;

  assign accept   = push && !full;
  assign job_push = accept && (op_t'(opcode) == OP_TICK);
  assign job.addr  = rom_addr(phase);
  assign job.level = level;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      level <= LVL_W'(AMP_STEPS);
    end else if (accept) begin
      unique case (op_t'(opcode))
        OP_TICK: begin
          // advance phase, wrap after the last step
          if (phase == PHASE_W'(TABLE_DEPTH - 1)) begin
            phase <= '0;
          end else begin
            phase <= phase + 1'b1;
          end
        end
        OP_STEP: begin
          // raise or lower level, hold at the limits
          if (clockwise[0]) begin
            if (level != LVL_W'(AMP_STEPS)) begin
              level <= level + 1'b1;
            end
          end else if (level != '0) begin
            level <= level - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/spwm_back.sv =====
// Back end: turns one queued job into a compare value over four steps.
module spwm_back
  import spwm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [PERIOD_W-1:0] cfg_data,
  input  logic                job_empty,
  input  job_t                job,
  output logic                job_pop,
  input  logic                res_full,
  output logic                res_push,
  output res_t                res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SCALE,
    S_DIV,
    S_OUT
  } state_t;

  state_t              state;
  logic [PERIOD_W-1:0] period;
  job_t                job_q;
  logic signed [20:0]  prod;
  logic signed [21:0]  sum;
  logic [19:0]         sum_pos;
  logic [35:0]         scaled;
  logic [39:0]         recip;
  logic [16:0]         quot;

  assign sum     = HALF_SCALE + {prod[20], prod};
  assign sum_pos = sum[21] ? '0 : sum[19:0];
  assign quot    = recip[39:23];

  assign job_pop     = (state == S_IDLE) && !job_empty;
  assign res_push    = (state == S_OUT) && !res_full;
  assign res.compare = quot[16] ? {CMP_W{1'b1}} : quot[CMP_W-1:0];
  assign res.level   = job_q.level;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      period <= PERIOD_RESET;
    end else begin
      if (cfg_valid) begin
        period <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (!job_empty) begin
            job_q <= job;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= $signed({1'b0, job_q.level}) * SINE_ROM[job_q.addr];
          state <= S_SCALE;
        end
        S_SCALE: begin
          scaled <= period * sum_pos;
          state  <= S_DIV;
        end
        S_DIV: begin
          // divide by 655360: drop 16 bits, then multiply by 1/10
          recip <= scaled[35:16] * RECIP_TEN;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_mul_then_scale: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |=> state == S_SCALE)
    else $error("multiply step not followed by scale step");

  a_pop_starts_job: assert property (@(posedge clk) disable iff (rst)
    job_pop |=> state == S_MUL)
    else $error("job taken but work did not start");

  a_out_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && res_full) |=> state == S_OUT && $stable(recip))
    else $error("result dropped while output queue full");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    res_push |-> res.level <= LVL_W'(AMP_STEPS))
    else $error("result level out of range");
`endif

endmodule

// ===== hw/rtl/sine_pwm_amplitude_modulator.sv =====
// Top level of the sine PWM modulator: front end, job queue, back end, result queue.
//
//   channel   handshake           payload
//   input     push / full         opcode, clockwise
//   result    pop / empty         compare_value, amplitude_level
//   config    cfg_valid/cfg_ready cfg_data (pwm_period)
//
// An encoder step takes effect in the cycle it is accepted and gives no result.
// A period tick is written into the job queue when accepted and is taken from there by
// the back end once that is idle. Its result passes the sine multiply, period multiply,
// divide by ten and output steps and is then pushed into the result queue. The back end
// handles one tick at a time and takes the next only after that result is pushed.
// Reset: phase 0, level 10, period 2499, both queues empty. cfg_ready is always high.
// A full result queue stalls the back end; a full job queue raises full.
module sine_pwm_amplitude_modulator
  import spwm_pkg::*;
#(
  parameter int JOB_Q_DEPTH = JOB_DEPTH,
  parameter int RES_Q_DEPTH = RES_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [0:0]          opcode,
  input  logic [0:0]          clockwise,
  output logic                empty,
  input  logic                pop,
  output logic [CMP_W-1:0]    compare_value,
  output logic [LVL_W-1:0]    amplitude_level,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [PERIOD_W-1:0] cfg_data
);

  job_t job_in;
  job_t job_out;
  logic job_push;
  logic job_pop;
  logic job_full;
  logic job_empty;
  res_t res_in;
  res_t res_out;
  logic res_push;
  logic res_full;

  assign cfg_ready       = 1'b1;
  assign full            = job_full;
  assign compare_value   = res_out.compare;
  assign amplitude_level = res_out.level;

  spwm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .opcode    (opcode),
    .clockwise (clockwise),
    .full      (job_full),
    .job_push  (job_push),
    .job       (job_in)
  );

  spwm_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_Q_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  spwm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  spwm_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the sine PWM modulator: directed table, random ticks and steps, period sweeps.
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT = 2000;
  localparam longint MID_SUM = 327680;
  localparam longint SPAN    = 655360;
  localparam int NPHASE      = 7;

  // one quarter of the sine wave, Q1.15; the rest follows by symmetry
  localparam int QUARTER [17] = '{
    0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
    25330, 27246, 28899, 30274, 31357, 32138, 32610, 32767
  };

  typedef struct {
    spwm_pkg::op_t    op;
    logic             cw;
    int               reps;
    logic             typed;
    logic [15:0]      cmp;
    logic [3:0]       lvl;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [0:0]  opcode = spwm_pkg::OP_TICK;
  logic [0:0]  clockwise = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [15:0] compare_value;
  logic [3:0]  amplitude_level;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  // modulator state as the testbench sees it
  logic [15:0] period_now = spwm_pkg::PERIOD_RESET;
  logic [5:0]  phase_now = '0;
  logic [3:0]  level_now = 4'(spwm_pkg::AMP_STEPS);

  spwm_pkg::res_t compare_q [$];
  int  errors = 0;
  int  quiet = 0;
  bit  calm = 1'b1;

  plan_row_t plan [9] = '{
    '{spwm_pkg::OP_TICK, 1'b0, 1,  1'b1, 16'd1249, 4'd10},
    '{spwm_pkg::OP_STEP, 1'b1, 1,  1'b0, 16'd0,    4'd0},
    '{spwm_pkg::OP_TICK, 1'b1, 1,  1'b0, 16'd0,    4'd0},
    '{spwm_pkg::OP_STEP, 1'b0, 11, 1'b0, 16'd0,    4'd0},
    '{spwm_pkg::OP_TICK, 1'b0, 1,  1'b1, 16'd1249, 4'd0},
    '{spwm_pkg::OP_STEP, 1'b0, 1,  1'b0, 16'd0,    4'd0},
    '{spwm_pkg::OP_TICK, 1'b1, 1,  1'b1, 16'd1249, 4'd0},
    '{spwm_pkg::OP_STEP, 1'b1, 1,  1'b0, 16'd0,    4'd0},
    '{spwm_pkg::OP_TICK, 1'b0, 1,  1'b0, 16'd0,    4'd0}
  };

  sine_pwm_amplitude_modulator u_dut (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .opcode          (opcode),
    .clockwise       (clockwise),
    .empty           (empty),
    .pop             (pop),
    .compare_value   (compare_value),
    .amplitude_level (amplitude_level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one item, hold it until accepted, then update the model and, for a tick, queue its compare.
  task automatic apply_input(input spwm_pkg::op_t op, input logic cw,
                             input logic typed, input spwm_pkg::res_t given);
    spwm_pkg::res_t r;
    int             mag;
    int             sample;
    longint         sum;
    longint         cmp;
    push      <= 1'b1;
    opcode    <= op;
    clockwise <= cw;
    do @(posedge clk); while (full);
    if (op == spwm_pkg::OP_STEP) begin
      if (cw) begin
        if (level_now < 4'(spwm_pkg::AMP_STEPS)) level_now = level_now + 4'd1;
      end else if (level_now > 4'd0) begin
        level_now = level_now - 4'd1;
      end
    end else begin
      mag = (phase_now[4:0] <= 5'd16) ? QUARTER[phase_now[4:0]] : QUARTER[32 - phase_now[4:0]];
      sample = phase_now[5] ? -mag : mag;
      sum = MID_SUM + longint'(level_now) * longint'(sample);
      if (sum < 0) sum = 0;
      cmp = (longint'(period_now) * sum) / SPAN;
      if (cmp > 65535) cmp = 65535;
      r.compare = cmp[15:0];
      r.level   = level_now;
      compare_q.push_back(typed ? given : r);
      phase_now = phase_now + 6'd1;
    end
  endtask

  // Drop push and wait until every compare is back and the block is quiet.
  task automatic settle();
    push <= 1'b0;
    while (compare_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    spwm_pkg::res_t given;
    spwm_pkg::op_t  op;
    logic [15:0]    periods [NPHASE];
    int             counts [NPHASE];
    int             tick_pct;
    int             cw_pct;
    periods = '{16'd65535, 16'd1, 16'd0, 16'($urandom_range(1, 65535)),
                16'($urandom_range(1, 65535)), spwm_pkg::PERIOD_RESET,
                16'($urandom_range(1, 65535))};
    counts = '{280, 145, 145, 145, 145, 145, 145};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      given.compare = plan[i].cmp;
      given.level   = plan[i].lvl;
      repeat (plan[i].reps) apply_input(plan[i].op, plan[i].cw, plan[i].typed, given);
    end

    for (int k = 0; k < NPHASE; k++) begin
      settle();
      cfg_valid <= 1'b1;
      cfg_data  <= periods[k];
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      period_now = periods[k];
      calm = (k == 3) || (k == NPHASE - 1);
      tick_pct = $urandom_range(35, 85);
      cw_pct   = $urandom_range(20, 80);
      for (int n = 0; n < counts[k]; n++) begin
        if (!calm && $urandom_range(0, 7) == 0) begin
          push <= 1'b0;
          repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        op = ($urandom_range(0, 99) < tick_pct) ? spwm_pkg::OP_TICK : spwm_pkg::OP_STEP;
        apply_input(op, 1'($urandom_range(0, 99) < cw_pct), 1'b0, given);
      end
    end

    settle();
    if (errors == 0 && compare_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Result side: check each popped compare, stall in bursts, and hold off once to fill the block.
  initial begin
    spwm_pkg::res_t want;
    int stall_left;
    int seen;
    bit held;
    stall_left = 0;
    seen = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        seen++;
        if (compare_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected item: compare %0d level %0d", compare_value, amplitude_level);
        end else begin
          want = compare_q.pop_front();
          if (compare_value !== want.compare || amplitude_level !== want.level) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: compare exp %0d got %0d, level exp %0d got %0d",
                       want.compare, compare_value, want.level, amplitude_level);
          end
        end
      end
      if (rst) begin
        pop <= 1'b0;
      end else begin
        if (!held && seen >= 100) begin
          held = 1'b1;
          stall_left = 150;
        end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 13);
        end
        if (stall_left > 0) begin
          stall_left--;
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  // Abort when nothing moves on any channel for too long.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

endmodule
